FILE: hw/rtl/wbsd_pkg.sv
// shared types and constants for the white blob steering decision unit
// no dependencies; the design files refer to it by scoped names, the bench files import it
`default_nettype none

package wbsd_pkg;

    // fixed field widths
    localparam int CH_W      = 8;
    localparam int CFG_W     = 13;
    localparam int CODE_W    = 3;
    localparam int REG_IDX_W = 2;

    // a channel at full scale marks a white pixel
    localparam logic [CH_W-1:0] CH_FULL = 8'hFF;

    // register reset values and default row limit
    localparam logic [CFG_W-1:0] ROW_WIDTH_RST     = 13'd640;
    localparam logic [CFG_W-1:0] LEFT_BAND_RST     = 13'd192;
    localparam logic [CFG_W-1:0] MIDDLE_BAND_RST   = 13'd256;
    localparam int               MAX_ROW_WIDTH_DEF = 4096;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROW_WIDTH   = 2'd0,
        REG_LEFT_BAND   = 2'd1,
        REG_MIDDLE_BAND = 2'd2
    } reg_idx_t;

    typedef enum logic [CODE_W-1:0] {
        STEER_STOP       = 3'd0,
        STEER_FORWARD    = 3'd1,
        STEER_SLOW_LEFT  = 3'd2,
        STEER_TURN_LEFT  = 3'd3,
        STEER_SLOW_RIGHT = 3'd4,
        STEER_TURN_RIGHT = 3'd5,
        STEER_NONE       = 3'd6
    } steer_t;

    // progress of the first white run in a row
    typedef enum logic [1:0] {
        RUN_NONE   = 2'd0,
        RUN_ACTIVE = 2'd1,
        RUN_DONE   = 2'd2
    } run_phase_t;

    // one registered pixel handed to the row tracker
    typedef struct packed {
        logic valid;
        logic white;
        logic last;
    } pix_step_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wbsd_if.sv
// channel interfaces: pixel stream, steering result stream, register writes
// depends on wbsd_pkg for field widths
`default_nettype none

interface wbsd_pix_if;
    logic                     valid;
    logic                     ready;
    logic [wbsd_pkg::CH_W-1:0] red;
    logic [wbsd_pkg::CH_W-1:0] green;
    logic [wbsd_pkg::CH_W-1:0] blue;
    logic                     frame_end;

    modport source (output valid, red, green, blue, frame_end, input ready);
    modport sink   (input valid, red, green, blue, frame_end, output ready);
endinterface

interface wbsd_res_if;
    logic                       valid;
    logic                       ready;
    logic [wbsd_pkg::CODE_W-1:0] steer_code;
    logic [wbsd_pkg::CFG_W-1:0]  left_count;
    logic [wbsd_pkg::CFG_W-1:0]  middle_count;
    logic [wbsd_pkg::CFG_W-1:0]  right_count;

    modport source (output valid, steer_code, left_count, middle_count, right_count,
                    input ready);
    modport sink   (input valid, steer_code, left_count, middle_count, right_count,
                    output ready);
endinterface

interface wbsd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [wbsd_pkg::REG_IDX_W-1:0] index;
    logic [wbsd_pkg::CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/white_blob_steering_decision_unit.sv
// result path: an accepted frame_end pixel goes through the pixel register, then loads the result register
// throughput: one pixel per cycle; only a frame_end pixel waits while a result is unread
// the figure is set by the single pixel register feeding the row tracker state update
// reset: asynchronous, active low; registers return to 640/192/256, frame state cleared
// top level of the white blob steering decision unit
// depends on wbsd_pkg, wbsd_if, wbsd_row_tracker and wbsd_decide
`default_nettype none

module white_blob_steering_decision_unit #(
    parameter int MAX_ROW_WIDTH = wbsd_pkg::MAX_ROW_WIDTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    wbsd_pix_if.sink   pix,
    wbsd_res_if.source res,
    wbsd_cfg_if.sink   cfg
);

    localparam int CNT_W = $clog2(MAX_ROW_WIDTH + 1);
    localparam int CFG_W = wbsd_pkg::CFG_W;
    localparam int SUM_W = CFG_W + 1;
    // wide enough to compare the register against the row limit
    localparam int CLP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // configuration registers
    logic [CFG_W-1:0] row_width_reg;
    logic [CFG_W-1:0] left_band_reg;
    logic [CFG_W-1:0] middle_band_reg;

    // pixel register
    logic s1_valid_reg;
    logic s1_white_reg;
    logic s1_last_reg;

    // result register
    logic                       res_valid_reg;
    wbsd_pkg::steer_t           res_code_reg;
    logic [2:0][CFG_W-1:0]      res_count_reg;

    logic                       pix_accept;
    logic                       s1_fire;
    logic [CNT_W-1:0]           width_eff;
    logic [SUM_W-1:0]           mid_end;
    logic [2:0][CNT_W-1:0]      lat_upd;
    wbsd_pkg::steer_t           steer;
    wbsd_pkg::pix_step_t        step;

    // ---------------------------------------------------------------
    // register writes: always ready, unknown indexes are dropped
    // ---------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg   <= wbsd_pkg::ROW_WIDTH_RST;
            left_band_reg   <= wbsd_pkg::LEFT_BAND_RST;
            middle_band_reg <= wbsd_pkg::MIDDLE_BAND_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                wbsd_pkg::REG_ROW_WIDTH:   row_width_reg   <= cfg.data;
                wbsd_pkg::REG_LEFT_BAND:   left_band_reg   <= cfg.data;
                wbsd_pkg::REG_MIDDLE_BAND: middle_band_reg <= cfg.data;
                default:                   ;
            endcase
        end
    end

    // effective row width: zero acts as one, clipped to the row limit
    always_comb
    begin
        if (row_width_reg == '0)
            width_eff = CNT_W'(1);
        else if (CLP_W'(row_width_reg) > CLP_W'(MAX_ROW_WIDTH))
            width_eff = CNT_W'(MAX_ROW_WIDTH);
        else
            width_eff = CNT_W'(row_width_reg);
    end

    // end of the middle band, one bit wider so it cannot wrap
    assign mid_end = SUM_W'(left_band_reg) + SUM_W'(middle_band_reg);

    // ---------------------------------------------------------------
    // pixel register: moves on every cycle, except a frame end pixel
    // that must wait for the result register to empty
    // ---------------------------------------------------------------
    assign s1_fire    = s1_valid_reg && (!s1_last_reg || !res_valid_reg || res.ready);
    assign pix.ready  = !s1_valid_reg || s1_fire;
    assign pix_accept = pix.valid && pix.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (pix.ready)
            s1_valid_reg <= pix.valid;
    end

    // payload needs no reset; white is resolved before registering
    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            s1_white_reg <= (pix.red == wbsd_pkg::CH_FULL) &&
                            (pix.green == wbsd_pkg::CH_FULL) &&
                            (pix.blue == wbsd_pkg::CH_FULL);
            s1_last_reg  <= pix.frame_end;
        end
    end

    assign step.valid = s1_fire;
    assign step.white = s1_white_reg;
    assign step.last  = s1_last_reg;

    // ---------------------------------------------------------------
    // row state and decision
    // ---------------------------------------------------------------
    wbsd_row_tracker #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_row_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .width_eff (width_eff),
        .left_band (left_band_reg),
        .mid_end   (mid_end),
        .lat_upd   (lat_upd)
    );

    // counts already include a latch made by the closing partial row
    wbsd_decide #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_decide (
        .counts    (lat_upd),
        .width_eff (width_eff),
        .steer     (steer)
    );

    // ---------------------------------------------------------------
    // result register: one transaction per frame
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (s1_fire && s1_last_reg)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last_reg)
        begin
            res_code_reg <= steer;
            for (int k = 0; k < 3; k++)
            begin
                res_count_reg[k] <= CFG_W'(lat_upd[k]);
            end
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.steer_code   = res_code_reg;
    assign res.left_count   = res_count_reg[0];
    assign res.middle_count = res_count_reg[1];
    assign res.right_count  = res_count_reg[2];

endmodule

`default_nettype wire

FILE: hw/rtl/wbsd_row_tracker.sv
// per-row white counting, first-run band counts and drop latch
// depends on wbsd_pkg (run phase enum, pixel step struct)
`default_nettype none

module wbsd_row_tracker #(
    parameter  int MAX_ROW_WIDTH = wbsd_pkg::MAX_ROW_WIDTH_DEF,
    localparam int CNT_W         = $clog2(MAX_ROW_WIDTH + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire wbsd_pkg::pix_step_t          step,
    input  wire logic [CNT_W-1:0]             width_eff,
    input  wire logic [wbsd_pkg::CFG_W-1:0]   left_band,
    input  wire logic [wbsd_pkg::CFG_W:0]     mid_end,
    output logic      [2:0][CNT_W-1:0]        lat_upd
);

    localparam int CMP_W = (CNT_W > wbsd_pkg::CFG_W + 1) ? CNT_W : wbsd_pkg::CFG_W + 1;

    logic [CNT_W-1:0]       col_reg,        col_next;
    logic                   first_reg,      first_next;
    logic [CNT_W-1:0]       row_total_reg,  row_total_next;
    logic [CNT_W-1:0]       prev_total_reg, prev_total_next;
    wbsd_pkg::run_phase_t   phase_reg,      phase_next;
    logic [2:0][CNT_W-1:0]  row_band_reg,   row_band_next;
    logic [2:0][CNT_W-1:0]  prev_band_reg,  prev_band_next;
    logic [2:0][CNT_W-1:0]  lat_reg,        lat_next;
    logic                   latched_reg,    latched_next;

    logic [1:0]             band;
    logic                   in_run;
    logic [CNT_W-1:0]       total_upd;
    logic [2:0][CNT_W-1:0]  band_upd;
    wbsd_pkg::run_phase_t   phase_upd;
    logic [CNT_W:0]         col_plus;
    logic                   close_row;
    logic                   latch_now;

    // band of the current column
    always_comb
    begin
        if (CMP_W'(col_reg) < CMP_W'(left_band))
            band = 2'd0;
        else if (CMP_W'(col_reg) < CMP_W'(mid_end))
            band = 2'd1;
        else
            band = 2'd2;
    end

    assign in_run    = (phase_reg != wbsd_pkg::RUN_DONE);
    assign total_upd = step.white ? row_total_reg + CNT_W'(1) : row_total_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            band_upd[k] = (step.white && in_run && band == 2'(k)) ?
                          row_band_reg[k] + CNT_W'(1) : row_band_reg[k];
        end
    end

    always_comb
    begin
        case (phase_reg)
            wbsd_pkg::RUN_NONE:   phase_upd = step.white ? wbsd_pkg::RUN_ACTIVE : wbsd_pkg::RUN_NONE;
            wbsd_pkg::RUN_ACTIVE: phase_upd = step.white ? wbsd_pkg::RUN_ACTIVE : wbsd_pkg::RUN_DONE;
            wbsd_pkg::RUN_DONE:   phase_upd = wbsd_pkg::RUN_DONE;
            default:              phase_upd = wbsd_pkg::RUN_NONE;
        endcase
    end

    // row closes on the last column or on frame end
    assign col_plus  = (CNT_W + 1)'(col_reg) + (CNT_W + 1)'(1);
    assign close_row = step.last || (col_plus >= (CNT_W + 1)'(width_eff));
    assign latch_now = close_row && !first_reg && !latched_reg &&
                       (total_upd < prev_total_reg);

    assign lat_upd = latch_now ? prev_band_reg : lat_reg;

    always_comb
    begin
        col_next        = col_reg;
        first_next      = first_reg;
        row_total_next  = row_total_reg;
        prev_total_next = prev_total_reg;
        phase_next      = phase_reg;
        row_band_next   = row_band_reg;
        prev_band_next  = prev_band_reg;
        lat_next        = lat_reg;
        latched_next    = latched_reg;
        if (step.valid)
        begin
            if (step.last)
            begin
                // frame done: clear everything for the next frame
                col_next        = '0;
                first_next      = 1'b1;
                row_total_next  = '0;
                prev_total_next = '0;
                phase_next      = wbsd_pkg::RUN_NONE;
                row_band_next   = '0;
                prev_band_next  = '0;
                lat_next        = '0;
                latched_next    = 1'b0;
            end
            else if (close_row)
            begin
                col_next        = '0;
                first_next      = 1'b0;
                row_total_next  = '0;
                prev_total_next = total_upd;
                phase_next      = wbsd_pkg::RUN_NONE;
                row_band_next   = '0;
                prev_band_next  = band_upd;
                lat_next        = lat_upd;
                latched_next    = latched_reg || latch_now;
            end
            else
            begin
                col_next       = col_plus[CNT_W-1:0];
                row_total_next = total_upd;
                phase_next     = phase_upd;
                row_band_next  = band_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            first_reg      <= 1'b1;
            row_total_reg  <= '0;
            prev_total_reg <= '0;
            phase_reg      <= wbsd_pkg::RUN_NONE;
            row_band_reg   <= '0;
            prev_band_reg  <= '0;
            lat_reg        <= '0;
            latched_reg    <= 1'b0;
        end
        else
        begin
            col_reg        <= col_next;
            first_reg      <= first_next;
            row_total_reg  <= row_total_next;
            prev_total_reg <= prev_total_next;
            phase_reg      <= phase_next;
            row_band_reg   <= row_band_next;
            prev_band_reg  <= prev_band_next;
            lat_reg        <= lat_next;
            latched_reg    <= latched_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/wbsd_decide.sv
// steering decision tree over the three latched band counts
// depends on wbsd_pkg (steering code enum)
`default_nettype none

module wbsd_decide #(
    parameter  int MAX_ROW_WIDTH = wbsd_pkg::MAX_ROW_WIDTH_DEF,
    localparam int CNT_W         = $clog2(MAX_ROW_WIDTH + 1)
) (
    input  wire logic [2:0][CNT_W-1:0] counts,
    input  wire logic [CNT_W-1:0]      width_eff,
    output wbsd_pkg::steer_t           steer
);

    logic [CNT_W+1:0] total;
    logic [CNT_W:0]   x_twice;
    logic [CNT_W:0]   z_twice;
    logic             x_nz, y_nz, z_nz;

    assign x_nz    = (counts[0] != '0);
    assign y_nz    = (counts[1] != '0);
    assign z_nz    = (counts[2] != '0);
    assign total   = (CNT_W + 2)'(counts[0]) + (CNT_W + 2)'(counts[1]) +
                     (CNT_W + 2)'(counts[2]);
    assign x_twice = {counts[0], 1'b0};
    assign z_twice = {counts[2], 1'b0};

    always_comb
    begin
        if (x_nz)
        begin
            if (y_nz && z_nz)
                steer = (total == (CNT_W + 2)'(width_eff)) ?
                        wbsd_pkg::STEER_STOP : wbsd_pkg::STEER_FORWARD;
            else if (y_nz)
                steer = ((CNT_W + 1)'(counts[1]) >= x_twice) ?
                        wbsd_pkg::STEER_SLOW_LEFT : wbsd_pkg::STEER_TURN_LEFT;
            else
                steer = z_nz ? wbsd_pkg::STEER_NONE : wbsd_pkg::STEER_TURN_LEFT;
        end
        else if (y_nz)
        begin
            if (z_nz)
                steer = ((CNT_W + 1)'(counts[1]) >= z_twice) ?
                        wbsd_pkg::STEER_SLOW_RIGHT : wbsd_pkg::STEER_TURN_RIGHT;
            else
                steer = wbsd_pkg::STEER_FORWARD;
        end
        else
        begin
            steer = z_nz ? wbsd_pkg::STEER_TURN_RIGHT : wbsd_pkg::STEER_STOP;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/wbsd_checker.sv
// port-level checks on the white blob steering decision unit, bound to the top
// depends on wbsd_pkg for widths and steering codes
`default_nettype none

module wbsd_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         pix_ready,
    input  wire logic                         res_valid,
    input  wire logic                         res_ready,
    input  wire logic [wbsd_pkg::CODE_W-1:0]  res_steer_code,
    input  wire logic [wbsd_pkg::CFG_W-1:0]   res_left_count,
    input  wire logic [wbsd_pkg::CFG_W-1:0]   res_middle_count,
    input  wire logic [wbsd_pkg::CFG_W-1:0]   res_right_count
);

    // a stalled result transaction holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_steer_code) &&
        $stable(res_left_count) && $stable(res_middle_count) &&
        $stable(res_right_count))
        else $error("result changed while stalled");

    // with no result pending the pixel side never stalls
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> pix_ready)
        else $error("pixel stream stalled with result register empty");

    // no latched row means stop
    a_empty_stop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_left_count == '0 && res_middle_count == '0 &&
        res_right_count == '0 |-> res_steer_code == wbsd_pkg::STEER_STOP)
        else $error("empty latch gave a code other than stop");

    // left and middle bands only: a left turn of some kind
    a_left_turn: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_left_count != '0 && res_middle_count != '0 &&
        res_right_count == '0 |->
        res_steer_code == wbsd_pkg::STEER_SLOW_LEFT ||
        res_steer_code == wbsd_pkg::STEER_TURN_LEFT)
        else $error("left and middle bands gave a code other than a left turn");

endmodule

bind white_blob_steering_decision_unit wbsd_checker u_wbsd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .pix_ready        (pix.ready),
    .res_valid        (res.valid),
    .res_ready        (res.ready),
    .res_steer_code   (res.steer_code),
    .res_left_count   (res.left_count),
    .res_middle_count (res.middle_count),
    .res_right_count  (res.right_count)
);

`default_nettype wire

FILE: bench/wbsd_steer_checker.sv
// frame checker for the white blob steering decision unit: follows register writes and
// pixels, works out each frame's steering result and compares it with the result channel
// depends on wbsd_pkg and the channel interfaces of wbsd_if
module wbsd_steer_checker (
    input  logic clk,
    input  logic rst_n,
    wbsd_pix_if  pix,
    wbsd_res_if  res,
    wbsd_cfg_if  cfg,
    output int   mismatches,
    output int   outstanding,
    output int   results_checked
);
    import wbsd_pkg::*;

    typedef struct packed {
        steer_t           code;
        logic [CFG_W-1:0] left_cnt;
        logic [CFG_W-1:0] mid_cnt;
        logic [CFG_W-1:0] right_cnt;
    } steer_report_t;

    steer_report_t steer_due_q[$];

    // register copies
    logic [CFG_W-1:0] row_width_reg;
    logic [CFG_W-1:0] left_band_reg;
    logic [CFG_W-1:0] middle_band_reg;

    // frame state
    int         col;
    bit         first_row;
    int         row_whites;
    int         prev_row_whites;
    run_phase_t run_state;
    int         band_now [3];
    int         band_prev [3];
    int         band_hold [3];
    bit         latched;

    int fail_tally    = 0;
    int checked_tally = 0;

    task automatic clear_frame_state();
        col             = 0;
        first_row       = 1'b1;
        row_whites      = 0;
        prev_row_whites = 0;
        run_state       = RUN_NONE;
        band_now        = '{0, 0, 0};
        band_prev       = '{0, 0, 0};
        band_hold       = '{0, 0, 0};
        latched         = 1'b0;
    endtask

    function automatic steer_t steer_for(input int x, input int y, input int z, input int span);
        if (x != 0)
        begin
            if (y != 0)
            begin
                if (z != 0)
                    return (x + y + z == span) ? STEER_STOP : STEER_FORWARD;
                return (y >= 2 * x) ? STEER_SLOW_LEFT : STEER_TURN_LEFT;
            end
            return (z == 0) ? STEER_TURN_LEFT : STEER_NONE;
        end
        if (y != 0)
        begin
            if (z != 0)
                return (y >= 2 * z) ? STEER_SLOW_RIGHT : STEER_TURN_RIGHT;
            return STEER_FORWARD;
        end
        return (z != 0) ? STEER_TURN_RIGHT : STEER_STOP;
    endfunction

    task automatic track_pixel(input logic white, input logic last);
        int            span;
        int            mid_end;
        int            zone;
        steer_report_t due;
        span    = (row_width_reg == 0) ? 1 :
                  (int'(row_width_reg) > MAX_ROW_WIDTH_DEF) ? MAX_ROW_WIDTH_DEF :
                  int'(row_width_reg);
        mid_end = int'(left_band_reg) + int'(middle_band_reg);
        zone    = (col < int'(left_band_reg)) ? 0 : (col < mid_end) ? 1 : 2;

        // only the first contiguous run feeds the band counts
        if (white)
        begin
            row_whites++;
            if (run_state != RUN_DONE)
            begin
                band_now[zone]++;
                run_state = RUN_ACTIVE;
            end
        end
        else if (run_state == RUN_ACTIVE)
        begin
            run_state = RUN_DONE;
        end

        if (last || col + 1 >= span)
        begin
            if (!first_row && !latched && row_whites < prev_row_whites)
            begin
                band_hold = band_prev;
                latched   = 1'b1;
            end
            prev_row_whites = row_whites;
            band_prev       = band_now;
            band_now        = '{0, 0, 0};
            row_whites      = 0;
            run_state       = RUN_NONE;
            col             = 0;
            first_row       = 1'b0;
        end
        else
        begin
            col++;
        end

        if (last)
        begin
            due.code      = steer_for(band_hold[0], band_hold[1], band_hold[2], span);
            due.left_cnt  = CFG_W'(band_hold[0]);
            due.mid_cnt   = CFG_W'(band_hold[1]);
            due.right_cnt = CFG_W'(band_hold[2]);
            steer_due_q.push_back(due);
            clear_frame_state();
        end
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got)
        begin
            fail_tally++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        steer_report_t due;
        if (!rst_n)
        begin
            row_width_reg   = ROW_WIDTH_RST;
            left_band_reg   = LEFT_BAND_RST;
            middle_band_reg = MIDDLE_BAND_RST;
            clear_frame_state();
            steer_due_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (reg_idx_t'(cfg.index))
                    REG_ROW_WIDTH:   row_width_reg   = cfg.data;
                    REG_LEFT_BAND:   left_band_reg   = cfg.data;
                    REG_MIDDLE_BAND: middle_band_reg = cfg.data;
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready)
            begin
                track_pixel(pix.red == CH_FULL && pix.green == CH_FULL && pix.blue == CH_FULL,
                            pix.frame_end);
            end
            if (res.valid && res.ready)
            begin
                if (steer_due_q.size() == 0)
                begin
                    fail_tally++;
                    $display({"%0t: unexpected result, expected none, ",
                              "got code %0d counts %0d/%0d/%0d"},
                             $time, res.steer_code, res.left_count, res.middle_count,
                             res.right_count);
                end
                else
                begin
                    due = steer_due_q.pop_front();
                    check_field("steer_code", int'(due.code), int'(res.steer_code));
                    check_field("left_count", int'(due.left_cnt), int'(res.left_count));
                    check_field("middle_count", int'(due.mid_cnt), int'(res.middle_count));
                    check_field("right_count", int'(due.right_cnt), int'(res.right_count));
                    checked_tally++;
                end
            end
        end
        mismatches      <= fail_tally;
        outstanding     <= steer_due_q.size();
        results_checked <= checked_tally;
    end

endmodule

FILE: bench/tb_white_blob_steering_decision_unit.sv
// testbench top for the white blob steering decision unit: clock, reset, pixel and
// register stimulus, receiver back-pressure, watchdog and verdict
// depends on wbsd_pkg, wbsd_if, the block itself and wbsd_steer_checker
module tb_white_blob_steering_decision_unit;
    import wbsd_pkg::*;

    localparam int IDLE_LIMIT        = 2000;  // cycles without any transaction
    localparam int DRAIN_CYCLES      = 8;     // margin after the last result is taken
    localparam int RANDOM_PIXELS     = 1000;  // with directed and pressure frames, about 1300 in all
    localparam int MIN_RANDOM_FRAMES = 60;
    localparam int HOLD_CYCLES       = 300;   // long receiver hold-off
    localparam int PRESSURE_FRAMES   = 30;
    localparam int WIDE_ROW          = 32;    // wider rows only get short partial frames
    localparam int CORNER_COUNT      = 11;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    wbsd_pix_if pix ();
    wbsd_res_if res ();
    wbsd_cfg_if cfg ();

    int steer_mismatches;
    int steer_pending;
    int steer_results;

    // stimulus bookkeeping
    int pix_gap_pct   = 0;
    int res_stall_pct = 0;
    logic res_hold    = 1'b0;
    int pixels_sent   = 0;
    int frames_sent   = 0;
    int settings_used = 0;
    int quiet_cycles  = 0;

    // register extremes: zero width, single column, oversize width, empty and
    // oversize bands, no middle band, whole row in one band
    int corner_setup [CORNER_COUNT][3] = '{
        '{8, 2, 3}, '{10, 3, 0}, '{6, 0, 3}, '{5, 8191, 0}, '{7, 2, 8191},
        '{0, 0, 0}, '{1, 1, 0}, '{4096, 0, 4096}, '{8191, 8191, 8191},
        '{9, 0, 0}, '{12, 4, 4}
    };

    white_blob_steering_decision_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .res   (res),
        .cfg   (cfg)
    );

    wbsd_steer_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .pix             (pix),
        .res             (res),
        .cfg             (cfg),
        .mismatches      (steer_mismatches),
        .outstanding     (steer_pending),
        .results_checked (steer_results)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result receiver: random stalls, plus a forced hold-off while res_hold is set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res.ready <= 1'b0;
        else
            res.ready <= !res_hold && ($urandom_range(99) >= res_stall_pct);
    end

    // watchdog: a long stretch with no transaction on any channel means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (pix.valid && pix.ready) || (res.valid && res.ready) ||
            (cfg.valid && cfg.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin pix_gap_pct = 65; res_stall_pct <= 0;  end
            IDLE_RECEIVER: begin pix_gap_pct = 0;  res_stall_pct <= 65; end
            IDLE_BOTH:     begin pix_gap_pct = 17; res_stall_pct <= 17; end
            default:       begin pix_gap_pct = 0;  res_stall_pct <= 0;  end
        endcase
    endtask

    // one pixel transaction; non-white pixels are often white in two channels
    task automatic send_shade(input bit white, input bit last);
        logic [CH_W-1:0] shade [3];
        int pick;
        if (white)
            shade = '{CH_FULL, CH_FULL, CH_FULL};
        else if ($urandom_range(2) == 0)
            shade = '{CH_W'($urandom_range(255)), CH_W'($urandom_range(255)),
                      CH_W'($urandom_range(255))};
        else
        begin
            shade = '{CH_FULL, CH_FULL, CH_FULL};
            pick = $urandom_range(2);
            shade[pick] = CH_W'($urandom_range(254));
        end
        while ($urandom_range(99) < pix_gap_pct)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid     <= 1'b1;
        pix.red       <= shade[0];
        pix.green     <= shade[1];
        pix.blue      <= shade[2];
        pix.frame_end <= last;
        do @(posedge clk); while (!pix.ready);
        pixels_sent++;
        if (last)
            frames_sent++;
    endtask

    // pattern letters: w white, o other; capitals carry frame_end
    task automatic send_pattern(input string pat);
        byte ch;
        int i;
        for (i = 0; i < pat.len(); i++)
        begin
            ch = pat[i];
            send_shade(ch == "w" || ch == "W", ch == "W" || ch == "O");
        end
    endtask

    // writes all three registers in one burst, valid held high throughout
    task automatic program_bands(input int w, input int l, input int m);
        reg_idx_t         order [3];
        logic [CFG_W-1:0] vals [3];
        int k;
        order = '{REG_ROW_WIDTH, REG_LEFT_BAND, REG_MIDDLE_BAND};
        vals  = '{CFG_W'(w), CFG_W'(l), CFG_W'(m)};
        cfg.valid <= 1'b1;
        for (k = 0; k < 3; k++)
        begin
            cfg.index <= order[k];
            cfg.data  <= vals[k];
            do @(posedge clk); while (!cfg.ready);
        end
        cfg.valid <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // waits for every outstanding result, then for the pipeline to empty
    task automatic settle_block();
        pix.valid <= 1'b0;
        do @(posedge clk); while (steer_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // a frame of a few rows, each row at most one white run at a random place, sometimes
    // with stray whites after it; the last row is sometimes cut short by frame_end.
    // with close clear the frame is left open for a register change mid frame
    task automatic send_frame(input int span, input bit close);
        int rows, reach, r, c, kind, start, len, col_end;
        bit scatter, white;
        reach = (span > WIDE_ROW) ? 16 : span;
        rows  = (span > WIDE_ROW) ? 1 : $urandom_range(1, 5);
        for (r = 0; r < rows; r++)
        begin
            kind    = $urandom_range(7);
            start   = $urandom_range(0, reach - 1);
            len     = $urandom_range(1, reach - start);
            scatter = ($urandom_range(2) == 0);
            if (kind == 0)
                len = 0;
            else if (kind == 1)
            begin
                start = 0;
                len   = reach;
            end
            col_end = span - 1;
            if (r == rows - 1 && (!close || span > WIDE_ROW || $urandom_range(2) == 0))
                col_end = $urandom_range(0, reach - 1);
            for (c = 0; c <= col_end; c++)
            begin
                if (c >= start && c < start + len)
                    white = 1'b1;
                else if (c <= start + len)
                    white = 1'b0;
                else
                    white = scatter && ($urandom_range(4) < 2);
                send_shade(white, close && r == rows - 1 && c == col_end);
            end
        end
    endtask

    task automatic send_phase(input int w, input int l, input int m, input idle_mode_t mode);
        int span;
        span = (w == 0) ? 1 : (w > MAX_ROW_WIDTH_DEF) ? MAX_ROW_WIDTH_DEF : w;
        program_bands(w, l, m);
        set_idling(mode);
        repeat ($urandom_range(2, 5)) send_frame(span, 1'b1);
        if ($urandom_range(3) == 0)
            send_frame(span, 1'b0);
        settle_block();
    endtask

    initial
    begin
        int base_pixels, base_frames, phase_no, w, l, m;

        pix.valid     <= 1'b0;
        pix.red       <= '0;
        pix.green     <= '0;
        pix.blue      <= '0;
        pix.frame_end <= 1'b0;
        cfg.valid     <= 1'b0;
        cfg.index     <= REG_ROW_WIDTH;
        cfg.data      <= '0;
        rst_n         <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: lone white pixel at reset widths, then a four column row with
        // one column in each of the left and middle bands: full row stop, turn right,
        // forward
        send_pattern("W");
        settle_block();
        program_bands(4, 1, 1);
        send_pattern("wwwwwooO");
        send_pattern("owwoooO");
        send_pattern("wwoowwwowO");
        settle_block();

        // random frames, register corners first
        base_pixels = pixels_sent;
        base_frames = frames_sent;
        phase_no    = 0;
        while (pixels_sent - base_pixels < RANDOM_PIXELS ||
               frames_sent - base_frames < MIN_RANDOM_FRAMES)
        begin
            if (phase_no < CORNER_COUNT)
            begin
                w = corner_setup[phase_no][0];
                l = corner_setup[phase_no][1];
                m = corner_setup[phase_no][2];
            end
            else
            begin
                w = $urandom_range(1, 16);
                case ($urandom_range(7))
                    0:       l = 0;
                    1:       l = 8191;
                    default: l = $urandom_range(0, w);
                endcase
                case ($urandom_range(7))
                    0:       m = 0;
                    1:       m = 8191;
                    default: m = $urandom_range(0, w);
                endcase
            end
            send_phase(w, l, m, idle_mode_t'(phase_no % 4));
            phase_no++;
        end

        // back-pressure: receiver held off while short frames keep coming
        program_bands(3, 1, 1);
        set_idling(IDLE_NONE);
        fork
            begin
                res_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                res_hold <= 1'b0;
            end
        join_none
        repeat (PRESSURE_FRAMES) send_frame(3, 1'b1);
        settle_block();

        $display("covered %0d pixels in %0d frames across %0d register settings",
                 pixels_sent, frames_sent, settings_used);
        $display("checked %0d steering results, %0d mismatches",
                 steer_results, steer_mismatches);
        if (steer_mismatches == 0 && steer_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/wbsd_pkg.sv
hw/rtl/wbsd_if.sv
hw/rtl/wbsd_row_tracker.sv
hw/rtl/wbsd_decide.sv
hw/rtl/white_blob_steering_decision_unit.sv
hw/rtl/wbsd_checker.sv
bench/wbsd_steer_checker.sv
bench/tb_white_blob_steering_decision_unit.sv
